// ===== rtl/bcc_pkg.sv =====
// Shared constants for the bitset conjunction combine block.
// Holds the class codes, the pair table and the default word width; no dependencies.
package bcc_pkg;

    localparam int WORD_BITS_DEFAULT = 8;
    localparam int NUM_CLASSES       = 4;

    // Start/end classes of an alternating expression.
    localparam int CLS_ZZ = 0;
    localparam int CLS_ZO = 1;
    localparam int CLS_OZ = 2;
    localparam int CLS_OO = 3;

    // Bit c is set when class c keeps odd result positions, clear when it keeps even ones.
    localparam logic [NUM_CLASSES-1:0] CLS_ODD_POS = 4'b0110;

    // Entry c, bit (4 * left class + right class): that pair feeds class c.
    localparam logic [15:0] PAIR_ALLOWED [NUM_CLASSES] = '{
        16'b0001_0011_1101_1111,
        16'b0010_0000_1010_0000,
        16'b0100_1100_0000_0000,
        16'b1000_0000_0000_0000
    };

endpackage

// ===== rtl/bcc_class_len.sv =====
// Class length extraction for one operand of the conjunction.
// Finds the longest length of each start/end class; depends on bcc_pkg.
module bcc_class_len #(
    parameter int WORD_BITS = bcc_pkg::WORD_BITS_DEFAULT,
    localparam int LEN_W = $clog2(WORD_BITS + 1)
) (
    input  logic [WORD_BITS-1:0]                      zero_word,
    input  logic [WORD_BITS-1:0]                      one_word,
    output logic [bcc_pkg::NUM_CLASSES-1:0][LEN_W-1:0] len
);
    import bcc_pkg::*;

    always_comb
    begin
        len = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (zero_word[i])
            begin
                if (i % 2 == 0)
                    len[CLS_ZZ] = LEN_W'(i + 1);
                else
                    len[CLS_ZO] = LEN_W'(i + 1);
            end
            if (one_word[i])
            begin
                if (i % 2 == 0)
                    len[CLS_OO] = LEN_W'(i + 1);
                else
                    len[CLS_OZ] = LEN_W'(i + 1);
            end
        end
    end

endmodule

// ===== rtl/bcc_combine.sv =====
// Combination of the two operands' class lengths into the result words.
// Applies the sum-and-max pair rules and builds the length masks; depends on bcc_pkg.
module bcc_combine #(
    parameter int WORD_BITS = bcc_pkg::WORD_BITS_DEFAULT,
    localparam int LEN_W = $clog2(WORD_BITS + 1)
) (
    input  logic [bcc_pkg::NUM_CLASSES-1:0][LEN_W-1:0] left_len,
    input  logic [bcc_pkg::NUM_CLASSES-1:0][LEN_W-1:0] right_len,
    input  logic                                       left_one_bit0,
    input  logic                                       right_one_bit0,
    output logic [WORD_BITS-1:0]                       result_start_zero,
    output logic [WORD_BITS-1:0]                       result_start_one
);
    import bcc_pkg::*;

    localparam int SUM_W = LEN_W + 1;

    logic [NUM_CLASSES-1:0][SUM_W-1:0]     best;
    logic [NUM_CLASSES-1:0]                found;
    logic [NUM_CLASSES-1:0][WORD_BITS-1:0] class_mask;

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        best  = '0;
        found = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            for (int p = 0; p < NUM_CLASSES; p++)
            begin
                for (int q = 0; q < NUM_CLASSES; q++)
                begin
                    sum = SUM_W'(left_len[p]) + SUM_W'(right_len[q]) - SUM_W'(1);
                    if (PAIR_ALLOWED[c][4 * p + q] && left_len[p] != '0
                        && right_len[q] != '0 && (!found[c] || sum > best[c]))
                    begin
                        best[c]  = sum;
                        found[c] = 1'b1;
                    end
                end
            end
        end
    end

    // Keeping only positions of the class parity below the length also covers
    // the step that lowers a length of the wrong parity by one.
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                class_mask[c][i] = found[c] && (SUM_W'(i) < best[c])
                                   && ((i % 2 == 1) == CLS_ODD_POS[c]);
            end
        end
    end

    always_comb
    begin
        result_start_zero   = class_mask[CLS_ZZ] | class_mask[CLS_ZO];
        result_start_one    = class_mask[CLS_OZ] | class_mask[CLS_OO];
        result_start_one[0] = left_one_bit0 & right_one_bit0;
    end

endmodule

// ===== rtl/bitset_conjunction_combine_top.sv =====
// Top level of the bitset conjunction combine block.
// Input register, class length extraction, combination and output register;
// depends on bcc_pkg, bcc_class_len and bcc_combine.
//
//   channel   direction  tdata fields (low bit up)                     beats
//   s_axis    in         left/right start_zero/start_one words           1 per item
//   m_axis    out        result_start_zero, result_start_one            1 per item
//
// One beat is taken per cycle unless a stalled output backs up into the input register; a result
// passes through the input register and then the output register around the logic.
// Reset clears only the valid flags; no clearing pass is needed.
// A stalled output holds its beat while the input register still takes one more.
module bitset_conjunction_combine_top #(
    parameter int WORD_BITS = bcc_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // left_start_zero, left_start_one, right_start_zero, right_start_one, zero fill
    input  logic [((4 * WORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // result_start_zero, result_start_one, zero fill
    output logic [((2 * WORD_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import bcc_pkg::*;

    localparam int LEN_W = $clog2(WORD_BITS + 1);
    localparam int IN_W  = 4 * WORD_BITS;
    localparam int OUT_W = ((2 * WORD_BITS + 7) / 8) * 8;

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic [IN_W-1:0]                     s1_data_reg;
    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [OUT_W-1:0]                    m_data_reg;
    logic [OUT_W-1:0]                    m_data_next;
    logic                                in_take;
    logic                                out_load;
    logic [NUM_CLASSES-1:0][LEN_W-1:0]   left_len;
    logic [NUM_CLASSES-1:0][LEN_W-1:0]   right_len;
    logic [WORD_BITS-1:0]                res_zero;
    logic [WORD_BITS-1:0]                res_one;

    assign out_load      = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bcc_class_len #(.WORD_BITS(WORD_BITS)) u_left_len (
        .zero_word (s1_data_reg[WORD_BITS-1:0]),
        .one_word  (s1_data_reg[2*WORD_BITS-1:WORD_BITS]),
        .len       (left_len)
    );

    bcc_class_len #(.WORD_BITS(WORD_BITS)) u_right_len (
        .zero_word (s1_data_reg[3*WORD_BITS-1:2*WORD_BITS]),
        .one_word  (s1_data_reg[4*WORD_BITS-1:3*WORD_BITS]),
        .len       (right_len)
    );

    bcc_combine #(.WORD_BITS(WORD_BITS)) u_combine (
        .left_len          (left_len),
        .right_len         (right_len),
        .left_one_bit0     (s1_data_reg[WORD_BITS]),
        .right_one_bit0    (s1_data_reg[3*WORD_BITS]),
        .result_start_zero (res_zero),
        .result_start_one  (res_one)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;

        m_data_next = OUT_W'({res_one, res_zero});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= s_axis_tdata[IN_W-1:0];
        if (out_load)
            m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_start_one_bit0: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tdata[WORD_BITS]
                     == ($past(s1_data_reg[WORD_BITS]) && $past(s1_data_reg[3*WORD_BITS])))
        else $error("start-one bit 0 does not follow the AND of the operands");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> s1_valid_reg && m_valid_reg && !m_axis_tready)
        else $error("input stalled although the pipeline can move");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_axis_tready |=> m_valid_reg && $stable(m_data_reg))
        else $error("stalled result was lost or changed");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the input register");
`endif

endmodule
